/* hdl/isd3_pkg.sv */
`default_nettype none
package isd3_pkg;

  // Number of axes held in the state.
  localparam int AXES = 3;
  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HALFLIFE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = 2'd2;

  // Item modes.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_MOVE  = 2'd1;
  localparam logic [1:0] MODE_RESET = 2'd2;

  // Register reset values.
  localparam logic [23:0] HALFLIFE_RST = 24'd19661;
  localparam logic [31:0] LIMIT_RST    = 32'd655;

  // Divider geometry: one quotient bit per cycle.
  localparam int DIV_W   = 49;
  localparam int DEN_W   = 48;
  localparam int DIV_CNT_W = 6;

  // 2 ln2 in Q2.30 scaled up by 2^18, and 2^40 for the exponential term.
  localparam logic [DIV_W-1:0] Y_NUM = 49'd1488522236 << 18;
  localparam logic [DIV_W-1:0] E_NUM = 49'd1 << 40;
  // Half-life guard of 1e-5 s in Q.32.
  localparam logic [DEN_W-1:0] EPS_Q32 = 48'd42950;

  // Polynomial coefficients 0.48 and 0.235 in Q0.16, and 1.0 in Q16.16.
  localparam logic [31:0] C048_Q16  = 32'd31457;
  localparam logic [31:0] C0235_Q16 = 32'd15401;
  localparam logic [DEN_W-1:0] ONE_Q16 = 48'd65536;

  // Saturation bound of the wide intermediates.
  localparam logic [95:0] WIDE_LIM = 96'd1 << 62;

endpackage
`default_nettype wire

/* hdl/implicit_spring_damper_3axis.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | mode, vec_x/y/z, step_time
// out     | output    | out_valid/out_stall| pos_x/y/z, vel_x/y/z, moving
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick item runs two restoring divisions, five products for the polynomial
// and six per axis, each taken in two halves on the shared 32x32 multiplier
// and then recombined, and then the arrival test; a long step skips the rest
// of the polynomial and the second division.
// A move, reset, zero-step or unused-mode item goes straight to the arrival test.
// Reset is synchronous and active low; it zeroes the state of every axis.
// in_stall is high while an item is worked on; the result register holds
// one finished item, so the next item is taken while out_stall is high.
`default_nettype none
module implicit_spring_damper_3axis (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic signed [31:0]            in_vec_x,
  input  wire logic signed [31:0]            in_vec_y,
  input  wire logic signed [31:0]            in_vec_z,
  input  wire logic [15:0]                   in_step_time,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 out_pos_x,
  output logic signed [31:0]                 out_pos_y,
  output logic signed [31:0]                 out_pos_z,
  output logic signed [31:0]                 out_vel_x,
  output logic signed [31:0]                 out_vel_y,
  output logic signed [31:0]                 out_vel_z,
  output logic                               out_moving,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [isd3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);
  import isd3_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE    = 23'd1 << 0,
    S_DIV     = 23'd1 << 1,
    S_MQ_LO   = 23'd1 << 2,
    S_MQ_HI   = 23'd1 << 3,
    S_MQ_FIN  = 23'd1 << 4,
    S_Y_DONE  = 23'd1 << 5,
    S_U_DONE  = 23'd1 << 6,
    S_U2_DONE = 23'd1 << 7,
    S_U3_DONE = 23'd1 << 8,
    S_C2_DONE = 23'd1 << 9,
    S_C1_DONE = 23'd1 << 10,
    S_E_DONE  = 23'd1 << 11,
    S_AX_J0   = 23'd1 << 12,
    S_AX_J1   = 23'd1 << 13,
    S_AX_T    = 23'd1 << 14,
    S_AX_W1   = 23'd1 << 15,
    S_AX_W2   = 23'd1 << 16,
    S_AX_P    = 23'd1 << 17,
    S_AX_V    = 23'd1 << 18,
    S_MV_CHK  = 23'd1 << 19,
    S_MV_ACC  = 23'd1 << 20,
    S_MV_CMP  = 23'd1 << 21,
    S_FIN     = 23'd1 << 22
  } state_t;

  // Clamp a wide intermediate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (a < -64'sd2147483648) return 32'sh80000000;
    return a[31:0];
  endfunction

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic signed [31:0] pos_r [AXES];
  logic signed [31:0] pos_nxt [AXES];
  logic signed [31:0] vel_r [AXES];
  logic signed [31:0] vel_nxt [AXES];
  logic signed [31:0] goal_r [AXES];
  logic signed [31:0] goal_nxt [AXES];
  logic signed [31:0] in_vec [AXES];

  logic [23:0] hl_r, hl_nxt;
  logic [31:0] spd_r, spd_nxt, dst_r, dst_nxt;

  logic [15:0] dt_r, dt_nxt;
  logic [31:0] y_r, y_nxt, u_r, u_nxt;
  logic [35:0] u2_r, u2_nxt;
  logic [24:0] e_r, e_nxt;
  logic [DEN_W-1:0] dsum_r, dsum_nxt;

  logic [DIV_W-1:0] div_num_r, div_num_nxt, div_rem_r, div_rem_nxt, quo_r, quo_nxt;
  logic [DEN_W-1:0] div_den_r, div_den_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [DIV_W-1:0] div_trial;

  logic signed [63:0] mq_a_r, mq_a_nxt, mq_res_r, mq_res_nxt;
  logic [31:0] mq_b_r, mq_b_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic mq_sh24_r, mq_sh24_nxt;
  logic [63:0] mq_mag;
  logic [95:0] mq_full, mq_shift;
  logic [62:0] mq_sat;

  logic signed [63:0] j0_r, j0_nxt, j1_r, j1_nxt, t_r, t_nxt, w_r, w_nxt;
  logic signed [63:0] pos64, vel64, goal64, j1_now;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;

  logic [AX_W-1:0] ax_r, ax_nxt;
  logic phase_r, phase_nxt;
  logic [63:0] sum_r, sum_nxt;
  logic [64:0] sum_wide;
  logic moving_r, moving_nxt;
  logic signed [33:0] mv_val;
  logic [33:0] mv_mag;
  logic [31:0] mv_lim;

  logic out_valid_r, out_valid_nxt, out_load;
  logic signed [31:0] opos_r [AXES];
  logic signed [31:0] ovel_r [AXES];
  logic omov_r;

  assign in_vec[0] = in_vec_x;
  assign in_vec[1] = in_vec_y;
  assign in_vec[2] = in_vec_z;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // Values of the axis in hand, sign-extended to the intermediate width.
  assign pos64  = 64'(pos_r[ax_r]);
  assign vel64  = 64'(vel_r[ax_r]);
  assign goal64 = 64'(goal_r[ax_r]);
  assign j1_now = vel64 + mq_res_r;

  // Divider step: one quotient bit.
  assign div_trial = {div_rem_r[DIV_W-2:0], div_num_r[DIV_W-1]};

  // Product unit: magnitude halves in, then recombination and saturation.
  assign mq_mag   = mq_a_r[63] ? 64'(-mq_a_r) : 64'(mq_a_r);
  assign mq_full  = {prod_r, 32'd0} + {32'd0, lo_r};
  assign mq_shift = mq_sh24_r ? (mq_full >> 24) : (mq_full >> 16);
  assign mq_sat   = (mq_shift > WIDE_LIM) ? WIDE_LIM[62:0] : mq_shift[62:0];

  // Arrival test operands.
  assign mv_val = phase_r ? 34'(goal64 - pos64) : 34'(vel64);
  assign mv_mag = mv_val[33] ? 34'(-mv_val) : 34'(mv_val);
  assign mv_lim = phase_r ? dst_r : spd_r;
  assign sum_wide = {1'b0, sum_r} + {1'b0, prod_r};

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_r)
      S_MQ_LO: begin
        mul_a = mq_mag[31:0];
        mul_b = mq_b_r;
      end
      S_MQ_HI: begin
        mul_a = mq_mag[63:32];
        mul_b = mq_b_r;
      end
      S_MV_CHK: begin
        mul_a = mv_mag[31:0];
        mul_b = mv_mag[31:0];
      end
      S_MV_ACC: begin
        mul_a = mv_lim;
        mul_b = mv_lim;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    pos_nxt = pos_r;
    vel_nxt = vel_r;
    goal_nxt = goal_r;
    hl_nxt = hl_r;
    spd_nxt = spd_r;
    dst_nxt = dst_r;
    dt_nxt = dt_r;
    y_nxt = y_r;
    u_nxt = u_r;
    u2_nxt = u2_r;
    e_nxt = e_r;
    dsum_nxt = dsum_r;
    div_num_nxt = div_num_r;
    div_rem_nxt = div_rem_r;
    div_den_nxt = div_den_r;
    div_cnt_nxt = div_cnt_r;
    quo_nxt = quo_r;
    mq_a_nxt = mq_a_r;
    mq_b_nxt = mq_b_r;
    mq_sh24_nxt = mq_sh24_r;
    mq_res_nxt = mq_res_r;
    lo_nxt = lo_r;
    j0_nxt = j0_r;
    j1_nxt = j1_r;
    t_nxt = t_r;
    w_nxt = w_r;
    ax_nxt = ax_r;
    phase_nxt = phase_r;
    sum_nxt = sum_r;
    moving_nxt = moving_r;
    out_load = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    // Register writes.
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_HALFLIFE: hl_nxt = cfg_data[23:0];
        REG_SPEED:    spd_nxt = cfg_data;
        REG_DISTANCE: dst_nxt = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dt_nxt = in_step_time;
          for (int i = 0; i < AXES; i++) begin
            if (in_mode == MODE_MOVE) begin
              goal_nxt[i] = in_vec[i];
            end else if (in_mode == MODE_RESET) begin
              pos_nxt[i] = in_vec[i];
              goal_nxt[i] = in_vec[i];
              vel_nxt[i] = 32'sd0;
            end
          end
          if (in_mode == MODE_TICK && in_step_time != 16'd0) begin
            div_num_nxt = Y_NUM;
            div_den_nxt = {8'd0, hl_r, 16'd0} + EPS_Q32;
            div_rem_nxt = '0;
            div_cnt_nxt = '0;
            ret_nxt = S_Y_DONE;
            state_nxt = S_DIV;
          end else begin
            ax_nxt = '0;
            phase_nxt = 1'b0;
            sum_nxt = '0;
            state_nxt = S_MV_CHK;
          end
        end
      end
      S_DIV: begin
        div_num_nxt = div_num_r << 1;
        if (div_trial >= {1'b0, div_den_r}) begin
          div_rem_nxt = div_trial - {1'b0, div_den_r};
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          div_rem_nxt = div_trial;
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
          state_nxt = ret_r;
        end
      end
      S_MQ_LO: state_nxt = S_MQ_HI;
      S_MQ_HI: begin
        lo_nxt = prod_r;
        state_nxt = S_MQ_FIN;
      end
      S_MQ_FIN: begin
        mq_res_nxt = mq_a_r[63] ? -$signed({1'b0, mq_sat}) : $signed({1'b0, mq_sat});
        state_nxt = ret_r;
      end
      S_Y_DONE: begin
        y_nxt = (quo_r[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : quo_r[31:0];
        mq_a_nxt = {32'd0, y_nxt};
        mq_b_nxt = {16'd0, dt_r};
        mq_sh24_nxt = 1'b0;
        ret_nxt = S_U_DONE;
        state_nxt = S_MQ_LO;
      end
      S_U_DONE: begin
        u_nxt = mq_res_r[31:0];
        // A long step drives the exponential term to zero.
        if (mq_res_r[31:26] != '0) begin
          e_nxt = '0;
          ax_nxt = '0;
          state_nxt = S_AX_J0;
        end else begin
          mq_a_nxt = {32'd0, u_nxt};
          mq_b_nxt = u_nxt;
          ret_nxt = S_U2_DONE;
          state_nxt = S_MQ_LO;
        end
      end
      S_U2_DONE: begin
        u2_nxt = mq_res_r[35:0];
        mq_a_nxt = {28'd0, u2_nxt};
        mq_b_nxt = u_r;
        ret_nxt = S_U3_DONE;
        state_nxt = S_MQ_LO;
      end
      S_U3_DONE: begin
        dsum_nxt = ONE_Q16 + {16'd0, u_r};
        mq_a_nxt = mq_res_r;
        mq_b_nxt = C0235_Q16;
        ret_nxt = S_C2_DONE;
        state_nxt = S_MQ_LO;
      end
      S_C2_DONE: begin
        dsum_nxt = dsum_r + mq_res_r[DEN_W-1:0];
        mq_a_nxt = {28'd0, u2_r};
        mq_b_nxt = C048_Q16;
        ret_nxt = S_C1_DONE;
        state_nxt = S_MQ_LO;
      end
      S_C1_DONE: begin
        div_num_nxt = E_NUM;
        div_den_nxt = dsum_r + mq_res_r[DEN_W-1:0];
        div_rem_nxt = '0;
        div_cnt_nxt = '0;
        ret_nxt = S_E_DONE;
        state_nxt = S_DIV;
      end
      S_E_DONE: begin
        e_nxt = quo_r[24:0];
        ax_nxt = '0;
        state_nxt = S_AX_J0;
      end
      S_AX_J0: begin
        j0_nxt = pos64 - goal64;
        mq_a_nxt = j0_nxt;
        mq_b_nxt = y_r;
        mq_sh24_nxt = 1'b0;
        ret_nxt = S_AX_J1;
        state_nxt = S_MQ_LO;
      end
      S_AX_J1: begin
        j1_nxt = j1_now;
        mq_a_nxt = j1_now;
        mq_b_nxt = {16'd0, dt_r};
        ret_nxt = S_AX_T;
        state_nxt = S_MQ_LO;
      end
      S_AX_T: begin
        t_nxt = j0_r + mq_res_r;
        mq_a_nxt = j1_r;
        mq_b_nxt = y_r;
        ret_nxt = S_AX_W1;
        state_nxt = S_MQ_LO;
      end
      S_AX_W1: begin
        mq_a_nxt = mq_res_r;
        mq_b_nxt = {16'd0, dt_r};
        ret_nxt = S_AX_W2;
        state_nxt = S_MQ_LO;
      end
      S_AX_W2: begin
        w_nxt = vel64 - mq_res_r;
        mq_a_nxt = t_r;
        mq_b_nxt = {7'd0, e_r};
        mq_sh24_nxt = 1'b1;
        ret_nxt = S_AX_P;
        state_nxt = S_MQ_LO;
      end
      S_AX_P: begin
        pos_nxt[ax_r] = sat32(goal64 + mq_res_r);
        mq_a_nxt = w_r;
        ret_nxt = S_AX_V;
        state_nxt = S_MQ_LO;
      end
      S_AX_V: begin
        vel_nxt[ax_r] = sat32(mq_res_r);
        mq_sh24_nxt = 1'b0;
        if (ax_r == AX_W'(AXES - 1)) begin
          ax_nxt = '0;
          phase_nxt = 1'b0;
          sum_nxt = '0;
          state_nxt = S_MV_CHK;
        end else begin
          ax_nxt = ax_r + 1'b1;
          state_nxt = S_AX_J0;
        end
      end
      S_MV_CHK: begin
        // A component at or over the limit settles the test at once.
        if (mv_mag >= {2'd0, mv_lim}) begin
          moving_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MV_ACC;
        end
      end
      S_MV_ACC: begin
        sum_nxt = sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
        if (ax_r == AX_W'(AXES - 1)) begin
          state_nxt = S_MV_CMP;
        end else begin
          ax_nxt = ax_r + 1'b1;
          state_nxt = S_MV_CHK;
        end
      end
      S_MV_CMP: begin
        if (sum_r < prod_r) begin
          if (!phase_r) begin
            phase_nxt = 1'b1;
            ax_nxt = '0;
            sum_nxt = '0;
            state_nxt = S_MV_CHK;
          end else begin
            moving_nxt = 1'b0;
            state_nxt = S_FIN;
          end
        end else begin
          moving_nxt = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Wait for the result register to be free.
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control, state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      out_valid_r <= 1'b0;
      hl_r <= HALFLIFE_RST;
      spd_r <= LIMIT_RST;
      dst_r <= LIMIT_RST;
      ax_r <= '0;
      phase_r <= 1'b0;
      div_cnt_r <= '0;
      for (int i = 0; i < AXES; i++) begin
        pos_r[i] <= 32'sd0;
        vel_r[i] <= 32'sd0;
        goal_r[i] <= 32'sd0;
      end
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      hl_r <= hl_nxt;
      spd_r <= spd_nxt;
      dst_r <= dst_nxt;
      ax_r <= ax_nxt;
      phase_r <= phase_nxt;
      div_cnt_r <= div_cnt_nxt;
      pos_r <= pos_nxt;
      vel_r <= vel_nxt;
      goal_r <= goal_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dt_r <= dt_nxt;
    y_r <= y_nxt;
    u_r <= u_nxt;
    u2_r <= u2_nxt;
    e_r <= e_nxt;
    dsum_r <= dsum_nxt;
    div_num_r <= div_num_nxt;
    div_rem_r <= div_rem_nxt;
    div_den_r <= div_den_nxt;
    quo_r <= quo_nxt;
    mq_a_r <= mq_a_nxt;
    mq_b_r <= mq_b_nxt;
    mq_sh24_r <= mq_sh24_nxt;
    mq_res_r <= mq_res_nxt;
    lo_r <= lo_nxt;
    j0_r <= j0_nxt;
    j1_r <= j1_nxt;
    t_r <= t_nxt;
    w_r <= w_nxt;
    sum_r <= sum_nxt;
    moving_r <= moving_nxt;
    prod_r <= 64'(mul_a) * 64'(mul_b);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      opos_r <= pos_r;
      ovel_r <= vel_r;
      omov_r <= moving_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_pos_x  = opos_r[0];
  assign out_pos_y  = opos_r[1];
  assign out_pos_z  = opos_r[2];
  assign out_vel_x  = ovel_r[0];
  assign out_vel_y  = ovel_r[1];
  assign out_vel_z  = ovel_r[2];
  assign out_moving = omov_r;

`ifndef SYNTHESIS
  // An accepted item keeps the input side stalled in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // The axis counter never leaves the axis range.
  a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
    ax_r <= AX_W'(AXES - 1))
    else $error("axis counter out of range");

  // A new result appears only from the final state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final state");
`endif

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import isd3_pkg::*;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               moving;
  } motion_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [15:0] dt;
    bit          typed;
    motion_t     res;
  } stim_row_t;

  localparam longint unsigned TWO_LN2_Q30 = 64'd1488522236;
  localparam longint unsigned EPS_GUARD   = 64'd42950;
  localparam longint unsigned U_CEIL      = 64'd1 << 26;
  localparam logic [127:0]    MAG_CEIL    = 128'd1 << 62;
  // Mode code that the block leaves without effect.
  localparam logic [1:0]      MODE_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_mode;
  logic signed [31:0] in_vec_x;
  logic signed [31:0] in_vec_y;
  logic signed [31:0] in_vec_z;
  logic [15:0] in_step_time;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_vel_x;
  logic signed [31:0] out_vel_y;
  logic signed [31:0] out_vel_z;
  logic out_moving;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  implicit_spring_damper_3axis u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_vec_x(in_vec_x), .in_vec_y(in_vec_y), .in_vec_z(in_vec_z),
    .in_step_time(in_step_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_vel_z(out_vel_z),
    .out_moving(out_moving),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the smoother state and its registers.
  longint pos_m[3];
  longint vel_m[3];
  longint goal_m[3];
  longint unsigned hl_m;
  longint unsigned speed_m;
  longint unsigned dist_m;

  motion_t pending_q[$];
  int fail_count;
  int items_sent;
  int results_seen;
  bit quiet;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint clamp32(longint a);
    if (a > 64'sd2147483647) return 64'sd2147483647;
    if (a < -64'sd2147483648) return -64'sd2147483648;
    return a;
  endfunction

  // Signed times unsigned, shifted right with truncation toward zero and
  // the magnitude held at 2^62.
  function automatic longint fx_mul(longint a, longint unsigned b, int sh);
    logic [127:0] p;
    longint unsigned m;
    bit neg;
    neg = a < 0;
    m = neg ? longint'(0) - a : a;
    p = {64'd0, m} * {64'd0, b};
    p = p >> sh;
    if (p > MAG_CEIL) p = MAG_CEIL;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  // Rational approximation of exp(-u), result in Q1.24.
  function automatic longint unsigned decay_q24(longint unsigned u);
    longint unsigned u2, u3, d;
    if (u >= U_CEIL) return 0;
    u2 = (u * u) >> 16;
    u3 = (u2 * u) >> 16;
    d = 64'd65536 + u + ((64'd31457 * u2) >> 16) + ((64'd15401 * u3) >> 16);
    return (64'd1 << 40) / d;
  endfunction

  // Exact test of sum of squares against the squared limit.
  function automatic bit under_limit(longint v0, longint v1, longint v2,
                                     longint unsigned lim);
    longint vals[3];
    longint unsigned m;
    logic [64:0] sum;
    vals[0] = v0;
    vals[1] = v1;
    vals[2] = v2;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = vals[i] < 0 ? longint'(0) - vals[i] : vals[i];
      if (m >= lim) return 1'b0;
      sum = sum + {1'b0, m * m};
      if (sum[64]) sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
    end
    return sum[63:0] < lim * lim;
  endfunction

  // Implicit spring-damper advance by one time step.
  task automatic advance(longint unsigned dt);
    longint unsigned y, u, e;
    longint j0, j1, t, w;
    y = (TWO_LN2_Q30 << 18) / ((hl_m << 16) + EPS_GUARD);
    if (y > 64'hFFFF_FFFF) y = 64'hFFFF_FFFF;
    u = (y * dt) >> 16;
    e = decay_q24(u);
    for (int i = 0; i < 3; i++) begin
      j0 = pos_m[i] - goal_m[i];
      j1 = vel_m[i] + fx_mul(j0, y, 16);
      t = j0 + fx_mul(j1, dt, 16);
      w = vel_m[i] - fx_mul(fx_mul(j1, y, 16), dt, 16);
      pos_m[i] = clamp32(goal_m[i] + fx_mul(t, e, 24));
      vel_m[i] = clamp32(fx_mul(w, e, 24));
    end
  endtask

  task automatic predict_item(logic [1:0] mode, logic [31:0] vx, logic [31:0] vy,
                              logic [31:0] vz, logic [15:0] dt, output motion_t r);
    longint c[3];
    c[0] = longint'($signed(vx));
    c[1] = longint'($signed(vy));
    c[2] = longint'($signed(vz));
    for (int i = 0; i < 3; i++) begin
      if (mode == MODE_MOVE) begin
        goal_m[i] = c[i];
      end else if (mode == MODE_RESET) begin
        pos_m[i] = c[i];
        goal_m[i] = c[i];
        vel_m[i] = 0;
      end
    end
    if (mode == MODE_TICK && dt != 0) advance(64'(dt));
    r.pos_x = pos_m[0][31:0];
    r.pos_y = pos_m[1][31:0];
    r.pos_z = pos_m[2][31:0];
    r.vel_x = vel_m[0][31:0];
    r.vel_y = vel_m[1][31:0];
    r.vel_z = vel_m[2][31:0];
    r.moving = !(under_limit(vel_m[0], vel_m[1], vel_m[2], speed_m) &&
                 under_limit(goal_m[0] - pos_m[0], goal_m[1] - pos_m[1],
                             goal_m[2] - pos_m[2], dist_m));
  endtask

  // Offer one item, at times after a random gap; the expectation is queued on acceptance.
  task automatic send_item(logic [1:0] mode, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] vz, logic [15:0] dt, bit typed, motion_t tr);
    motion_t pr;
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode = mode;
    in_vec_x = vx;
    in_vec_y = vy;
    in_vec_z = vz;
    in_step_time = dt;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_item(mode, vx, vy, vz, dt, pr);
    pending_q.push_back(typed ? tr : pr);
    items_sent++;
    @(negedge clk);
  endtask

  // Register write once the block has drained.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    in_valid = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    case (idx)
      REG_HALFLIFE: hl_m = 64'(val[23:0]);
      REG_SPEED:    speed_m = 64'(val);
      REG_DISTANCE: dist_m = 64'(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      2: return 32'($signed($urandom_range(0, 4096)) - 2048);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 2048));
      2: return 16'd0;
      default: return 16'($urandom_range(600, 1200));
    endcase
  endfunction

  task automatic random_burst(int n);
    motion_t none;
    int pick;
    none = '0;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) send_item(MODE_TICK, $urandom(), $urandom(), $urandom(),
                               rand_step(), 1'b0, none);
      else if (pick < 16) send_item(MODE_MOVE, rand_coord(), rand_coord(), rand_coord(),
                                    16'($urandom()), 1'b0, none);
      else if (pick < 19) send_item(MODE_RESET, rand_coord(), rand_coord(), rand_coord(),
                                    16'($urandom()), 1'b0, none);
      else send_item(MODE_UNUSED, $urandom(), $urandom(), $urandom(), 16'($urandom()),
                     1'b0, none);
    end
  endtask

  // Random stalls on the result side, switched off for the final stretch.
  initial begin
    int burst;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall = 1'b0;
      end else if (burst > 0) begin
        out_stall = 1'b1;
        burst--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        burst = $urandom_range(0, 4);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    motion_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result item with nothing expected");
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (out_pos_x !== want.pos_x) begin
          $error("pos_x expected %0d got %0d", want.pos_x, out_pos_x); fail_count++;
        end
        if (out_pos_y !== want.pos_y) begin
          $error("pos_y expected %0d got %0d", want.pos_y, out_pos_y); fail_count++;
        end
        if (out_pos_z !== want.pos_z) begin
          $error("pos_z expected %0d got %0d", want.pos_z, out_pos_z); fail_count++;
        end
        if (out_vel_x !== want.vel_x) begin
          $error("vel_x expected %0d got %0d", want.vel_x, out_vel_x); fail_count++;
        end
        if (out_vel_y !== want.vel_y) begin
          $error("vel_y expected %0d got %0d", want.vel_y, out_vel_y); fail_count++;
        end
        if (out_vel_z !== want.vel_z) begin
          $error("vel_z expected %0d got %0d", want.vel_z, out_vel_z); fail_count++;
        end
        if (out_moving !== want.moving) begin
          $error("moving expected %0d got %0d", want.moving, out_moving); fail_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    motion_t none;
    int waited;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_TICK;
    in_vec_x = '0;
    in_vec_y = '0;
    in_vec_z = '0;
    in_step_time = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_HALFLIFE;
    cfg_data = '0;
    fail_count = 0;
    items_sent = 0;
    results_seen = 0;
    quiet = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pos_m[i] = 0; vel_m[i] = 0; goal_m[i] = 0;
    end
    hl_m = 64'(HALFLIFE_RST);
    speed_m = 64'(LIMIT_RST);
    dist_m = 64'(LIMIT_RST);
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed items: state after reset, extremes and the special cases.
    rows.push_back('{MODE_UNUSED, 32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF, 16'hFFFF,
                     1'b1, '{0, 0, 0, 0, 0, 0, 1'b0}});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'd0, 1'b1, '{0, 0, 0, 0, 0, 0, 1'b0}});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'hFFFF, 1'b1, '{0, 0, 0, 0, 0, 0, 1'b0}});
    rows.push_back('{MODE_RESET, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 1'b1,
                     '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1'b0}});
    rows.push_back('{MODE_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd0, 1'b1,
                     '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 1'b1}});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'd1, 1'b0, none});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'hFFFF, 1'b0, none});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'h5555, 1'b0, none});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'hAAAA, 1'b0, none});
    rows.push_back('{MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0,
                     1'b0, none});
    rows.push_back('{MODE_MOVE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'h1234,
                     1'b0, none});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'd800, 1'b0, none});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'd800, 1'b0, none});
    rows.push_back('{MODE_RESET, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'd0,
                     1'b1, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 1'b0}});
    rows.push_back('{MODE_UNUSED, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 16'h0, 1'b1,
                     '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 1'b0}});
    rows.push_back('{MODE_MOVE, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'd0, 1'b0, none});
    rows.push_back('{MODE_TICK, 0, 0, 0, 16'd3000, 1'b0, none});
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.mode, row.vx, row.vy, row.vz, row.dt, row.typed, row.res);
    end

    // Shortest nonzero half-life: the step is long enough that the goal is reached.
    write_reg(REG_HALFLIFE, 32'd1);
    send_item(MODE_RESET, 32'd100, 32'd200, 32'd300, 16'd0, 1'b1,
              '{100, 200, 300, 0, 0, 0, 1'b0});
    send_item(MODE_MOVE, 32'h1234_5678, 32'h8765_4321, 32'h0, 16'd0, 1'b0, none);
    send_item(MODE_TICK, 0, 0, 0, 16'hFFFF, 1'b1,
              '{32'h1234_5678, 32'h8765_4321, 0, 0, 0, 0, 1'b0});
    random_burst(80);

    write_reg(REG_HALFLIFE, 32'hFFFF_FFFF);
    write_reg(REG_SPEED, 32'd0);
    write_reg(REG_DISTANCE, 32'd0);
    random_burst(80);

    write_reg(REG_HALFLIFE, 32'd65536);
    write_reg(REG_SPEED, 32'hFFFF_FFFF);
    write_reg(REG_DISTANCE, 32'hFFFF_FFFF);
    random_burst(80);

    write_reg(REG_HALFLIFE, 32'd6554);
    write_reg(REG_SPEED, 32'h0001_0000);
    write_reg(REG_DISTANCE, 32'd655);
    random_burst(80);

    write_reg(REG_HALFLIFE, 32'(HALFLIFE_RST));
    write_reg(REG_SPEED, 32'h5555_5555);
    write_reg(REG_DISTANCE, 32'hAAAA_AAAA);
    random_burst(80);

    write_reg(REG_HALFLIFE, $urandom_range(1, 24'hFFFFFF));
    write_reg(REG_SPEED, $urandom_range(0, 1 << 20));
    write_reg(REG_DISTANCE, $urandom_range(0, 1 << 20));
    random_burst(80);

    // Final stretch at full rate on both sides.
    quiet = 1'b1;
    random_burst(60);
    in_valid = 1'b0;

    waited = 0;
    while (pending_q.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (300) @(negedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d expected result items never arrived", pending_q.size());
      fail_count++;
    end
    $display("Covered %0d items over seven register settings, %0d results checked.",
             items_sent, results_seen);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
